>>> rtl/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue.
package spq_pkg;

   localparam int JOB_W  = 32;
   localparam int PRIO_W = 8;

   localparam logic       OP_INSERT    = 1'b0;
   localparam logic       OP_REMOVE    = 1'b1;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;

   // One queue slot.
   typedef struct packed {
      logic              valid;
      logic [JOB_W-1:0]  job;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      logic              insert;
      logic              remove;
      logic [JOB_W-1:0]  job;
      logic [PRIO_W-1:0] prio;
   } cmd_type;

endpackage

>>> rtl/spq_cell.sv
// One compare-and-shift cell of the sorted queue row.
// Depends on spq_pkg for the entry and command types.
module spq_cell (
   input  logic               clock,
   input  logic               reset,
   input  spq_pkg::cmd_type   cmd,
   input  logic               left_gt,
   input  spq_pkg::entry_type left_entry,
   input  spq_pkg::entry_type right_entry,
   output logic               gt,
   output spq_pkg::entry_type entry,
   output spq_pkg::entry_type entry_next
);

   logic                       valid_ff, valid_in;
   logic [spq_pkg::JOB_W-1:0]  job_ff, job_in;
   logic [spq_pkg::PRIO_W-1:0] prio_ff, prio_in;

   // An empty slot counts as holding a larger priority, so the insert lands in it.
   assign gt = !valid_ff || (prio_ff > cmd.prio);

   always_comb begin
      valid_in = valid_ff;
      job_in   = job_ff;
      prio_in  = prio_ff;
      if (cmd.insert && gt) begin
         if (left_gt) begin
            valid_in = left_entry.valid;
            job_in   = left_entry.job;
            prio_in  = left_entry.prio;
         end else begin
            valid_in = 1'b1;
            job_in   = cmd.job;
            prio_in  = cmd.prio;
         end
      end else if (cmd.remove) begin
         valid_in = right_entry.valid;
         job_in   = right_entry.job;
         prio_in  = right_entry.prio;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      prio_ff <= prio_in;
   end

   assign entry      = '{valid: valid_ff, job: job_ff, prio: prio_ff};
   assign entry_next = '{valid: valid_in, job: job_in, prio: prio_in};

endmodule

>>> rtl/sorted_priority_queue.sv
// Sorted priority queue: a row of CAPACITY compare-and-shift cells.
// A request beat's response is registered and shown in the cycle after its acceptance.
// One operation per cycle unless the response stalls; every cell moves in the same cycle.
// The output register takes a new beat whenever it is empty or being drained.
// Reset (synchronous, active high) empties the queue and the output register.
// Depends on spq_pkg and spq_cell.
module sorted_priority_queue #(
   parameter int CAPACITY = 32
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // job_code[31:0], priority_req[39:32]
   input  logic        req_tuser,   // operation[0]
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // head_valid[0], head_job[32:1], head_priority[40:33],
                                    // entry_total[46:41], zero pad[47]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // The count the queue holds; it only moves together with the cell row.
   logic [CNT_W-1:0] count_ff, count_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [47:0]      rsp_data_ff, rsp_data_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;

   logic             accept;
   logic             full, empty;
   logic [1:0]       status;
   spq_pkg::cmd_type cmd;

   logic                 gt_w         [CAPACITY];
   spq_pkg::entry_type   entry_w      [CAPACITY];
   spq_pkg::entry_type   entry_next_w [CAPACITY];

   // The response register is the only stage; it may be refilled while it drains.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign full  = (count_ff == CNT_W'(CAPACITY));
   assign empty = (count_ff == '0);

   always_comb begin
      cmd.job    = req_tdata[31:0];
      cmd.prio   = req_tdata[39:32];
      cmd.insert = accept && (req_tuser == spq_pkg::OP_INSERT) && !full;
      cmd.remove = accept && (req_tuser == spq_pkg::OP_REMOVE) && !empty;
   end

   always_comb begin
      status = spq_pkg::ST_DONE;
      if (req_tuser == spq_pkg::OP_INSERT) begin
         if (full) begin
            status = spq_pkg::ST_OVERFLOW;
         end
      end else begin
         if (empty) begin
            status = spq_pkg::ST_UNDERFLOW;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.remove) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // The cell row. The head cell has no left neighbor; the tail cell refills
   // with an empty slot when the queue moves toward the head.
   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic               left_gt;
         spq_pkg::entry_type left_entry;
         spq_pkg::entry_type right_entry;

         if (gi == 0) begin : g_head
            assign left_gt    = 1'b0;
            assign left_entry = '0;
         end else begin : g_body
            assign left_gt    = gt_w[gi-1];
            assign left_entry = entry_w[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_tail
            assign right_entry = '0;
         end else begin : g_inner
            assign right_entry = entry_w[gi+1];
         end

         spq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .cmd         (cmd),
            .left_gt     (left_gt),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .gt          (gt_w[gi]),
            .entry       (entry_w[gi]),
            .entry_next  (entry_next_w[gi])
         );
      end
   endgenerate

   // Response contents come from the head cell's next value, so the beat
   // reports the queue as it stands after the operation.
   always_comb begin
      logic [7:0]                 count_wide;
      logic [spq_pkg::JOB_W-1:0]  head_job;
      logic [spq_pkg::PRIO_W-1:0] head_prio;
      count_wide = 8'(count_in);
      head_job   = entry_next_w[0].valid ? entry_next_w[0].job  : '0;
      head_prio  = entry_next_w[0].valid ? entry_next_w[0].prio : '0;

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status;
         rsp_data_in   = {1'b0, count_wide[5:0], head_prio, head_job,
                          entry_next_w[0].valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   // The count never passes the capacity.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("queue count above capacity");

   // The head cell holds an entry exactly when the count is nonzero.
   a_head_matches_count : assert property (@(posedge clock) disable iff (reset)
      entry_w[0].valid == (count_ff != '0))
      else $error("head valid bit disagrees with count");

   // A rejected insert leaves the count alone.
   a_overflow_holds : assert property (@(posedge clock) disable iff (reset)
      accept && (req_tuser == spq_pkg::OP_INSERT) && full |=> count_ff == $past(count_ff))
      else $error("count moved on overflow");

   // Neighbors stay filled from the head and in ascending priority.
   generate
      for (gi = 0; gi < CAPACITY - 1; gi++) begin : g_order_chk
         a_sorted : assert property (@(posedge clock) disable iff (reset)
            entry_w[gi+1].valid |-> entry_w[gi].valid &&
                                     (entry_w[gi].prio <= entry_w[gi+1].prio))
            else $error("queue row out of order");
      end
   endgenerate

endmodule
